>>> hw/rtl/acs_pkg.sv
// types, codes and constants shared by the ata command sequencer modules
`timescale 1ns / 1ps
package acs_pkg;

  localparam int unsigned LBA_W = 28;

  // drive geometry and limits
  localparam logic [4:0] DEF_HEADS    = 5'd16;
  localparam logic [7:0] DEF_SPT      = 8'd63;
  localparam logic [7:0] MAX_MULTIPLE = 8'd128;

  // item kinds
  localparam logic KIND_COMMAND    = 1'b0;
  localparam logic KIND_CHUNK_DONE = 1'b1;

  // command codes
  localparam logic [7:0] CMD_INIT_PARAMS      = 8'h91;
  localparam logic [7:0] CMD_READ_SECTORS     = 8'h20;
  localparam logic [7:0] CMD_READ_SECTORS_NR  = 8'h21;
  localparam logic [7:0] CMD_READ_MULTIPLE    = 8'hC4;
  localparam logic [7:0] CMD_WRITE_SECTORS    = 8'h30;
  localparam logic [7:0] CMD_WRITE_SECTORS_NR = 8'h31;
  localparam logic [7:0] CMD_WRITE_MULTIPLE   = 8'hC5;
  localparam logic [7:0] CMD_SET_MULTIPLE     = 8'hC6;
  localparam logic [7:0] CMD_IDENTIFY         = 8'hEC;
  localparam logic [7:0] CMD_SET_FEATURES     = 8'hEF;
  localparam logic [3:0] CMD_NIB_RECALIBRATE  = 4'h1;
  localparam logic [3:0] CMD_NIB_SEEK         = 4'h7;

  // set features codes
  localparam logic [7:0] FEAT_EN_8BIT  = 8'h01;
  localparam logic [7:0] FEAT_DIS_8BIT = 8'h81;

  // status and error register values
  localparam logic [7:0] ST_READY  = 8'h50;
  localparam logic [7:0] ST_ERR    = 8'h01;
  localparam logic [7:0] ERR_NONE  = 8'h00;
  localparam logic [7:0] ERR_ABORT = 8'h04;

  // transfer kinds
  localparam logic [1:0] XFER_NONE     = 2'd0;
  localparam logic [1:0] XFER_IDENTIFY = 2'd1;
  localparam logic [1:0] XFER_READ     = 2'd2;
  localparam logic [1:0] XFER_WRITE    = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [7:0]       command_code;
    logic [7:0]       feature_code;
    logic [7:0]       sector_count;
    logic [7:0]       sector_number;
    logic [15:0]      cylinder;
    logic [7:0]       drive_head;
  } acs_in_t;

  typedef struct packed {
    logic [7:0]       status;
    logic [7:0]       error;
    logic [1:0]       transfer_kind;
    logic [LBA_W-1:0] transfer_lba;
    logic [7:0]       transfer_sectors;
    logic             last_chunk;
    logic             eight_bit_mode;
  } acs_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic commit;
  } acs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_mul;
  } acs_sts_t;

  function automatic logic is_rw_cmd(input logic [7:0] code);
    return (code == CMD_READ_SECTORS) || (code == CMD_READ_SECTORS_NR) ||
           (code == CMD_READ_MULTIPLE) || (code == CMD_WRITE_SECTORS) ||
           (code == CMD_WRITE_SECTORS_NR) || (code == CMD_WRITE_MULTIPLE);
  endfunction

endpackage

>>> hw/rtl/ata_command_sequencer.sv
// top level of the ata task-file command sequencer
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in_     | input     | in_valid / in_ready   | in_data (acs_in_t), one command
//          |           |                       | or chunk-accepted event
//  out_    | output    | out_valid / out_ready | out_data (acs_out_t), status,
//          |           |                       | error and transfer request
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_data, total_sectors
//
//  a transaction passes the states idle, mul1 and done from accept to result;
//    a chs read or write also passes mul2, as its address goes through two registered
//    multiplies (cylinder * heads, then * sectors per track) before the range check and commit
//  the next transaction is taken once the previous one has committed to the
//    output register; the result may still be waiting there
//  a stalled output holds the finished transaction in the commit step
//  rst_n is synchronous; it clears geometry, multiple count, 8-bit mode,
//    the pending transfer and total_sectors
`timescale 1ns / 1ps
module ata_command_sequencer import acs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  acs_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output acs_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LBA_W-1:0] cfg_data
);

  acs_cmd_t cmd;
  acs_sts_t sts;

  // capacity register always takes a write; the host is to write it only while idle
  assign cfg_ready = 1'b1;

  // state machine: accept, optional chs multiply, commit into output register
  acs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // decode, address mapping, chunking and drive settings
  acs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

>>> hw/rtl/acs_dp.sv
// datapath: task-file decode, chs multiply, transfer state and result register
`timescale 1ns / 1ps
module acs_dp import acs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  acs_cmd_t         cmd,
  output acs_sts_t         sts,
  input  acs_in_t          in_data,
  input  logic             cfg_we,
  input  logic [LBA_W-1:0] cfg_data,
  output acs_out_t         out_data
);

  acs_in_t          in_r;
  acs_out_t         out_r;
  logic [LBA_W-1:0] total_r;
  logic             xlat_valid_r, xlat_valid_nxt;
  logic [4:0]       log_heads_r, log_heads_nxt;
  logic [7:0]       log_spt_r, log_spt_nxt;
  logic [7:0]       mult_cnt_r, mult_cnt_nxt;
  logic             byte_mode_r, byte_mode_nxt;
  logic [LBA_W-1:0] next_lba_r, next_lba_nxt;
  logic [8:0]       left_r, left_nxt;
  logic             op_mult_r, op_mult_nxt;
  logic             op_write_r, op_write_nxt;
  logic [19:0]      prod1_r;
  logic [LBA_W-1:0] chs_lba_r;

  logic [4:0]       heads;
  logic [7:0]       spt;
  logic [20:0]      prod1_full;
  logic [28:0]      prod2_full;
  logic [3:0]       head_nib;
  logic             is_lba_mode;
  logic [LBA_W-1:0] start_lba;
  logic [8:0]       cnt_n;
  logic             new_mult, new_write;
  logic             range_bad;
  logic [LBA_W-1:0] ch_lba;
  logic [8:0]       ch_left, ch_n_full, ch_n, ch_rem;
  logic             ch_mult, ch_write;
  logic [LBA_W-1:0] ch_next;
  logic             do_chunk;
  logic [7:0]       err;
  logic [1:0]       xkind;
  logic [LBA_W-1:0] xlba;
  logic [7:0]       xsecs;
  logic             xlast;

  assign head_nib    = in_r.drive_head[3:0];
  assign is_lba_mode = in_r.drive_head[6];
  assign heads       = xlat_valid_r ? log_heads_r : DEF_HEADS;
  assign spt         = xlat_valid_r ? log_spt_r : DEF_SPT;

  // chs multiply in two registered steps
  assign prod1_full = {5'd0, in_r.cylinder} * {16'd0, heads} + {17'd0, head_nib};
  assign prod2_full = {9'd0, prod1_r} * {21'd0, spt} + {21'd0, in_r.sector_number} - 29'd1;

  assign sts.needs_mul = (in_r.kind == KIND_COMMAND) && is_rw_cmd(in_r.command_code) &&
                         !is_lba_mode;

  assign start_lba = is_lba_mode ? {head_nib, in_r.cylinder, in_r.sector_number} : chs_lba_r;
  assign cnt_n     = (in_r.sector_count == 8'd0) ? 9'd256 : {1'b0, in_r.sector_count};
  assign new_mult  = (in_r.command_code == CMD_READ_MULTIPLE) ||
                     (in_r.command_code == CMD_WRITE_MULTIPLE);
  assign new_write = (in_r.command_code == CMD_WRITE_SECTORS) ||
                     (in_r.command_code == CMD_WRITE_SECTORS_NR) ||
                     (in_r.command_code == CMD_WRITE_MULTIPLE);
  assign range_bad = ({1'b0, start_lba} + {20'd0, cnt_n}) > {1'b0, total_r};

  // chunk base: pending transfer, or the one a new command starts
  assign ch_lba   = (in_r.kind == KIND_CHUNK_DONE) ? next_lba_r : start_lba;
  assign ch_left  = (in_r.kind == KIND_CHUNK_DONE) ? left_r : cnt_n;
  assign ch_mult  = (in_r.kind == KIND_CHUNK_DONE) ? op_mult_r : new_mult;
  assign ch_write = (in_r.kind == KIND_CHUNK_DONE) ? op_write_r : new_write;

  assign ch_n_full = (ch_mult && (mult_cnt_r != 8'd0)) ? {1'b0, mult_cnt_r} : 9'd1;
  assign ch_n      = (ch_n_full > ch_left) ? ch_left : ch_n_full;
  assign ch_rem    = ch_left - ch_n;
  assign ch_next   = ch_lba + {19'd0, ch_n};

  always_comb begin
    xlat_valid_nxt = xlat_valid_r;
    log_heads_nxt  = log_heads_r;
    log_spt_nxt    = log_spt_r;
    mult_cnt_nxt   = mult_cnt_r;
    byte_mode_nxt  = byte_mode_r;
    next_lba_nxt   = next_lba_r;
    left_nxt       = left_r;
    op_mult_nxt    = op_mult_r;
    op_write_nxt   = op_write_r;
    do_chunk       = 1'b0;
    err            = ERR_NONE;
    xkind          = XFER_NONE;
    xlba           = '0;
    xsecs          = 8'd0;
    xlast          = 1'b0;
    if (in_r.kind == KIND_CHUNK_DONE) begin
      do_chunk = (left_r != 9'd0);
    end else begin
      left_nxt = 9'd0;
      if ((in_r.command_code[7:4] == CMD_NIB_RECALIBRATE) ||
          (in_r.command_code[7:4] == CMD_NIB_SEEK)) begin
        err = ERR_NONE;
      end else if (in_r.command_code == CMD_INIT_PARAMS) begin
        xlat_valid_nxt = 1'b1;
        log_spt_nxt    = in_r.sector_count;
        log_heads_nxt  = {1'b0, head_nib} + 5'd1;
      end else if (is_rw_cmd(in_r.command_code)) begin
        op_mult_nxt  = new_mult;
        op_write_nxt = new_write;
        if ((!is_lba_mode && (in_r.sector_number == 8'd0)) || range_bad) begin
          err = ERR_ABORT;
        end else begin
          do_chunk = 1'b1;
        end
      end else if (in_r.command_code == CMD_SET_MULTIPLE) begin
        if (in_r.sector_count > MAX_MULTIPLE) begin
          err = ERR_ABORT;
        end else begin
          mult_cnt_nxt = in_r.sector_count;
        end
      end else if (in_r.command_code == CMD_IDENTIFY) begin
        xkind = XFER_IDENTIFY;
        xsecs = 8'd1;
        xlast = 1'b1;
      end else if (in_r.command_code == CMD_SET_FEATURES) begin
        if (in_r.feature_code == FEAT_EN_8BIT) begin
          byte_mode_nxt = 1'b1;
        end else if (in_r.feature_code == FEAT_DIS_8BIT) begin
          byte_mode_nxt = 1'b0;
        end else begin
          err = ERR_ABORT;
        end
      end else begin
        err = ERR_ABORT;
      end
    end
    if (do_chunk) begin
      next_lba_nxt = ch_next;
      left_nxt     = ch_rem;
      xkind        = ch_write ? XFER_WRITE : XFER_READ;
      xlba         = ch_lba;
      xsecs        = ch_n[7:0];
      xlast        = (ch_rem == 9'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      xlat_valid_r <= 1'b0;
      log_heads_r  <= 5'd0;
      log_spt_r    <= 8'd0;
      mult_cnt_r   <= 8'd0;
      byte_mode_r  <= 1'b0;
      next_lba_r   <= '0;
      left_r       <= 9'd0;
      op_mult_r    <= 1'b0;
      op_write_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_r <= cfg_data;
      end
      if (cmd.commit) begin
        xlat_valid_r <= xlat_valid_nxt;
        log_heads_r  <= log_heads_nxt;
        log_spt_r    <= log_spt_nxt;
        mult_cnt_r   <= mult_cnt_nxt;
        byte_mode_r  <= byte_mode_nxt;
        next_lba_r   <= next_lba_nxt;
        left_r       <= left_nxt;
        op_mult_r    <= op_mult_nxt;
        op_write_r   <= op_write_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.mul1) begin
      prod1_r <= prod1_full[19:0];
    end
    if (cmd.mul2) begin
      chs_lba_r <= prod2_full[LBA_W-1:0];
    end
    if (cmd.commit) begin
      out_r.status           <= (err != ERR_NONE) ? (ST_READY | ST_ERR) : ST_READY;
      out_r.error            <= err;
      out_r.transfer_kind    <= xkind;
      out_r.transfer_lba     <= xlba;
      out_r.transfer_sectors <= xsecs;
      out_r.last_chunk       <= xlast;
      out_r.eight_bit_mode   <= byte_mode_nxt;
    end
  end

  assign out_data = out_r;

endmodule

>>> hw/rtl/acs_ctrl.sv
// controller: sequences one transaction through decode, multiply and commit
`timescale 1ns / 1ps
module acs_ctrl import acs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  acs_sts_t sts,
  output acs_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL1 = 2'd1;
  localparam logic [1:0] S_MUL2 = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  assign cmd.load   = in_valid && in_ready;
  assign cmd.mul1   = (state_r == S_MUL1);
  assign cmd.mul2   = (state_r == S_MUL2);
  assign cmd.commit = (state_r == S_DONE) && out_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        state_nxt = sts.needs_mul ? S_MUL2 : S_DONE;
      end
      S_MUL2: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_MUL1))
    else $error("accepted transaction did not enter the multiply step");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("commit did not present a result");

  a_mul2_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL2) |-> ($past(state_r) == S_MUL1))
    else $error("second multiply step entered out of order");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.commit)
    else $error("result register overwritten while held");

endmodule

>>> test/tb.sv
// testbench for the ata command sequencer: random and directed commands against a predictor
`timescale 1ns / 1ps

import acs_pkg::*;

class response_tracker;
  acs_out_t         expected_q[$];
  int unsigned      failures;

  // predicted drive state
  logic [LBA_W-1:0] capacity;
  bit               geom_valid;
  logic [4:0]       geom_heads;
  logic [7:0]       geom_spt;
  logic [7:0]       mult_count;
  bit               byte_mode;
  logic [LBA_W-1:0] next_lba;
  logic [8:0]       sectors_left;
  bit               op_multiple;
  bit               op_write;

  function new();
    failures     = 0;
    capacity     = '0;
    geom_valid   = 0;
    geom_heads   = '0;
    geom_spt     = '0;
    mult_count   = '0;
    byte_mode    = 0;
    next_lba     = '0;
    sectors_left = '0;
    op_multiple  = 0;
    op_write     = 0;
  endfunction

  function void set_capacity(logic [LBA_W-1:0] value);
    capacity = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function bit transfer_open();
    return sectors_left != 0;
  endfunction

  function acs_out_t status_only(logic [7:0] err);
    acs_out_t r;
    r = '0;
    r.status = (err != ERR_NONE) ? (ST_READY | ST_ERR) : ST_READY;
    r.error = err;
    r.eight_bit_mode = byte_mode;
    return r;
  endfunction

  function acs_out_t next_chunk();
    acs_out_t r;
    logic [8:0] n;
    n = 9'd1;
    if (op_multiple && mult_count != 0) n = {1'b0, mult_count};
    if (n > sectors_left) n = sectors_left;
    r = status_only(ERR_NONE);
    r.transfer_kind = op_write ? XFER_WRITE : XFER_READ;
    r.transfer_lba = next_lba;
    r.transfer_sectors = n[7:0];
    next_lba = next_lba + {19'd0, n};
    sectors_left = sectors_left - n;
    r.last_chunk = (sectors_left == 0);
    return r;
  endfunction

  function void note_command(acs_in_t c);
    acs_out_t r;
    longint unsigned addr, count, heads, spt;
    bit aborted;
    aborted = 0;
    if (c.kind == KIND_CHUNK_DONE) begin
      r = (sectors_left != 0) ? next_chunk() : status_only(ERR_NONE);
    end else begin
      // a new command drops whatever transfer was still open
      sectors_left = 0;
      if (c.command_code[7:4] == CMD_NIB_RECALIBRATE || c.command_code[7:4] == CMD_NIB_SEEK) begin
        r = status_only(ERR_NONE);
      end else begin
        case (c.command_code)
          CMD_INIT_PARAMS: begin
            geom_valid = 1;
            geom_spt = c.sector_count;
            geom_heads = {1'b0, c.drive_head[3:0]} + 5'd1;
            r = status_only(ERR_NONE);
          end
          CMD_READ_SECTORS, CMD_READ_SECTORS_NR, CMD_READ_MULTIPLE,
          CMD_WRITE_SECTORS, CMD_WRITE_SECTORS_NR, CMD_WRITE_MULTIPLE: begin
            count = (c.sector_count == 0) ? 64'd256 : 64'(c.sector_count);
            op_multiple = (c.command_code == CMD_READ_MULTIPLE) ||
                          (c.command_code == CMD_WRITE_MULTIPLE);
            op_write = (c.command_code == CMD_WRITE_SECTORS) ||
                       (c.command_code == CMD_WRITE_SECTORS_NR) ||
                       (c.command_code == CMD_WRITE_MULTIPLE);
            if (c.drive_head[6]) begin
              addr = 64'({c.drive_head[3:0], c.cylinder, c.sector_number});
            end else if (c.sector_number == 0) begin
              aborted = 1;
              addr = 64'd0;
            end else begin
              heads = 64'(geom_valid ? geom_heads : DEF_HEADS);
              spt = 64'(geom_valid ? geom_spt : DEF_SPT);
              addr = (64'(c.cylinder) * heads + 64'(c.drive_head[3:0])) * spt +
                     64'(c.sector_number) - 64'd1;
            end
            if (!aborted && addr + count > 64'(capacity)) aborted = 1;
            if (aborted) begin
              r = status_only(ERR_ABORT);
            end else begin
              next_lba = addr[LBA_W-1:0];
              sectors_left = count[8:0];
              r = next_chunk();
            end
          end
          CMD_SET_MULTIPLE: begin
            if (c.sector_count > MAX_MULTIPLE) begin
              r = status_only(ERR_ABORT);
            end else begin
              mult_count = c.sector_count;
              r = status_only(ERR_NONE);
            end
          end
          CMD_IDENTIFY: begin
            r = status_only(ERR_NONE);
            r.transfer_kind = XFER_IDENTIFY;
            r.transfer_sectors = 8'd1;
            r.last_chunk = 1'b1;
          end
          CMD_SET_FEATURES: begin
            if (c.feature_code == FEAT_EN_8BIT) begin
              byte_mode = 1;
              r = status_only(ERR_NONE);
            end else if (c.feature_code == FEAT_DIS_8BIT) begin
              byte_mode = 0;
              r = status_only(ERR_NONE);
            end else begin
              r = status_only(ERR_ABORT);
            end
          end
          default: r = status_only(ERR_ABORT);
        endcase
      end
    end
    expected_q.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %h, actual %h", name, exp_val, act_val);
      failures++;
    end
  endfunction

  function void check_result(acs_out_t got);
    acs_out_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: %h", got);
      failures++;
      return;
    end
    exp_r = expected_q.pop_front();
    compare_field("status", 32'(exp_r.status), 32'(got.status));
    compare_field("error", 32'(exp_r.error), 32'(got.error));
    compare_field("transfer_kind", 32'(exp_r.transfer_kind), 32'(got.transfer_kind));
    compare_field("transfer_lba", 32'(exp_r.transfer_lba), 32'(got.transfer_lba));
    compare_field("transfer_sectors", 32'(exp_r.transfer_sectors),
                  32'(got.transfer_sectors));
    compare_field("last_chunk", 32'(exp_r.last_chunk), 32'(got.last_chunk));
    compare_field("eight_bit_mode", 32'(exp_r.eight_bit_mode), 32'(got.eight_bit_mode));
  endfunction
endclass

module tb;

  localparam int QUIET_LIMIT = 2000;   // cycles without any transaction before giving up
  localparam int HOLD_CYCLES = 300;    // long output stall to fill the block
  localparam int DRAIN_GAP   = 8;      // extra idle cycles after the last expected result
  localparam int PHASE_ITEMS = 135;
  localparam logic [LBA_W-1:0] CAP_MAX = '1;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  acs_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  acs_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LBA_W-1:0] cfg_data;

  response_tracker  board;
  int               quiet_cycles;
  int unsigned      items_sent;
  int unsigned      in_idle_pct;
  int unsigned      out_idle_pct;
  bit               hold_output;
  logic [LBA_W-1:0] disk_sectors;     // capacity last written, for address picking

  logic [7:0] rw_codes [6] = '{CMD_READ_SECTORS, CMD_READ_SECTORS_NR, CMD_READ_MULTIPLE,
                               CMD_WRITE_SECTORS, CMD_WRITE_SECTORS_NR, CMD_WRITE_MULTIPLE};

  ata_command_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: every transaction is seen at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_command(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
      if (cfg_valid && cfg_ready) board.set_capacity(cfg_data);
      // watchdog: only a stretch with no transaction at all counts
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: random backpressure, plus one long hold counted here
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 0;
      end else begin
        out_ready = ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  function automatic acs_in_t cmd_item(logic [7:0] code, logic [7:0] feat, logic [7:0] cnt,
                                       logic [7:0] sec, logic [15:0] cyl, logic [7:0] dh);
    acs_in_t item;
    item.kind = KIND_COMMAND;
    item.command_code = code;
    item.feature_code = feat;
    item.sector_count = cnt;
    item.sector_number = sec;
    item.cylinder = cyl;
    item.drive_head = dh;
    return item;
  endfunction

  function automatic acs_in_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(acs_in_t)-1:0];
  endfunction

  // chunk-accepted event; the other fields carry noise the block must ignore
  function automatic acs_in_t chunk_item();
    acs_in_t item;
    item = random_item();
    item.kind = KIND_CHUNK_DONE;
    return item;
  endfunction

  // one input transaction; valid stays up afterwards until the next call drops or reuses it
  task automatic drive_request(input acs_in_t item);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = item;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // sender pause until every expected result is back, followed by an idle gap
  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // capacity write, only issued while the block is idle
  task automatic write_capacity(input logic [LBA_W-1:0] value);
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    disk_sectors = value;
  endtask

  // follow an open transfer with chunk-accepted events, sometimes abandoning it
  task automatic run_chunks(input int unsigned break_pct);
    while (board.transfer_open()) begin
      if ($urandom_range(99) < break_pct) break;
      drive_request(chunk_item());
    end
  endtask

  // one random group: a transfer sequence, a control command, or noise
  task automatic random_group();
    int unsigned      sel;
    int unsigned      n_sectors;
    logic [7:0]       cnt, sec, dh, code, feat;
    logic [15:0]      cyl;
    logic [LBA_W-1:0] lba;
    sel = $urandom_range(99);
    dh = 8'($urandom);
    feat = 8'($urandom);
    if (sel < 55) begin
      code = rw_codes[3'($urandom_range(5))];
      case ($urandom_range(9))
        0:       cnt = 8'd0;
        1, 2:    cnt = 8'($urandom_range(17, 255));
        default: cnt = 8'($urandom_range(1, 16));
      endcase
      n_sectors = (cnt == 0) ? 256 : 32'(cnt);
      if ($urandom_range(99) < 65) begin
        // lba mode, mostly inside the disk
        if (32'(disk_sectors) >= n_sectors && $urandom_range(99) < 90)
          lba = LBA_W'($urandom_range(32'(disk_sectors) - n_sectors));
        else
          lba = LBA_W'($urandom);
        dh[6] = 1'b1;
        dh[3:0] = lba[27:24];
        cyl = lba[23:8];
        sec = lba[7:0];
      end else begin
        // chs mode, sector 0 now and then
        dh[6] = 1'b0;
        cyl = ($urandom_range(1) != 0) ? 16'($urandom_range(40)) : 16'($urandom);
        sec = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      end
      drive_request(cmd_item(code, feat, cnt, sec, cyl, dh));
      run_chunks(3);
    end else if (sel < 80) begin
      cnt = 8'($urandom);
      sec = 8'($urandom);
      cyl = 16'($urandom);
      case ($urandom_range(6))
        0: code = CMD_INIT_PARAMS;
        1: begin
          code = CMD_SET_MULTIPLE;
          if ($urandom_range(9) < 7) cnt = 8'($urandom_range(0, 128));
        end
        2: begin
          code = CMD_SET_FEATURES;
          case ($urandom_range(4))
            0, 1:    feat = FEAT_EN_8BIT;
            2, 3:    feat = FEAT_DIS_8BIT;
            default: feat = 8'($urandom);
          endcase
        end
        3: code = CMD_IDENTIFY;
        4: code = {CMD_NIB_SEEK, 4'($urandom)};
        5: code = {CMD_NIB_RECALIBRATE, 4'($urandom)};
        default: code = 8'($urandom);
      endcase
      drive_request(cmd_item(code, feat, cnt, sec, cyl, dh));
    end else begin
      drive_request(random_item());
    end
  endtask

  // short directed pass over every command and corner
  task automatic directed_part();
    // capacity is 0 after reset, so any transfer is out of range
    drive_request(cmd_item(CMD_READ_SECTORS, 8'h00, 8'd1, 8'd0, 16'h0000, 8'hE0));
    wait_for_drain();
    write_capacity(CAP_MAX);
    drive_request(cmd_item(CMD_IDENTIFY, 8'h00, 8'd0, 8'd0, 16'h0000, 8'hA0));
    drive_request(cmd_item(CMD_SET_FEATURES, FEAT_EN_8BIT, 8'd0, 8'd0, 16'h0000, 8'hA0));
    drive_request(cmd_item(CMD_SET_FEATURES, 8'h55, 8'd0, 8'd0, 16'h0000, 8'hA0));
    drive_request(cmd_item(CMD_SET_FEATURES, FEAT_DIS_8BIT, 8'd0, 8'd0, 16'h0000, 8'hA0));
    drive_request(cmd_item(CMD_SET_MULTIPLE, 8'h00, 8'd129, 8'd0, 16'h0000, 8'hA0));
    drive_request(cmd_item(CMD_SET_MULTIPLE, 8'h00, MAX_MULTIPLE, 8'd0, 16'h0000, 8'hA0));
    // count 0 means 256, split in two full multiple chunks at the top of the disk
    drive_request(cmd_item(CMD_READ_MULTIPLE, 8'h00, 8'd0, 8'hFF, 16'hFFFE, 8'hEF));
    drive_request(chunk_item());
    // chunk accepted with nothing pending
    drive_request(chunk_item());
    // chs sector 0 is rejected
    drive_request(cmd_item(CMD_WRITE_SECTORS, 8'h00, 8'd2, 8'd0, 16'h0010, 8'hA0));
    // largest chs address on the default geometry
    drive_request(cmd_item(CMD_WRITE_SECTORS_NR, 8'hFF, 8'd2, 8'hFF, 16'hFFFF, 8'hAF));
    drive_request(chunk_item());
    // one past the end of the disk
    drive_request(cmd_item(CMD_READ_SECTORS, 8'h00, 8'd1, 8'hFF, 16'hFFFF, 8'hFF));
    // new command in the middle of a transfer drops the rest
    drive_request(cmd_item(CMD_READ_SECTORS_NR, 8'h00, 8'd3, 8'h00, 16'h0000, 8'h40));
    drive_request(cmd_item(CMD_IDENTIFY, 8'h00, 8'd0, 8'd0, 16'h0000, 8'hA0));
    drive_request(chunk_item());
    // logical geometry with zero sectors per track
    drive_request(cmd_item(CMD_INIT_PARAMS, 8'h00, 8'd0, 8'd0, 16'h0000, 8'hAF));
    drive_request(cmd_item(CMD_READ_SECTORS, 8'h00, 8'd1, 8'd9, 16'h0005, 8'hA3));
    drive_request(cmd_item(CMD_INIT_PARAMS, 8'h00, 8'd255, 8'd0, 16'h0000, 8'hA0));
    // multiple disabled, so multiple commands move one sector at a time
    drive_request(cmd_item(CMD_SET_MULTIPLE, 8'h00, 8'd0, 8'd0, 16'h0000, 8'hA0));
    drive_request(cmd_item(CMD_WRITE_MULTIPLE, 8'h00, 8'd2, 8'd7, 16'h0102, 8'h40));
    drive_request(chunk_item());
    drive_request(cmd_item({CMD_NIB_SEEK, 4'hF}, 8'h00, 8'd0, 8'd0, 16'h0000, 8'hA0));
    drive_request(cmd_item({CMD_NIB_RECALIBRATE, 4'h0}, 8'h00, 8'd0, 8'd0, 16'h0000, 8'hA0));
    drive_request(cmd_item(8'h00, 8'h00, 8'd0, 8'd0, 16'h0000, 8'hA0));
    drive_request(cmd_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF));
  endtask

  initial begin
    int unsigned phase_end;
    logic [LBA_W-1:0] cap;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet_cycles = 0;
    items_sent = 0;
    in_idle_pct = 28;
    out_idle_pct = 28;
    hold_output = 0;
    disk_sectors = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed_part();

    // random phases, each after a capacity write, the extremes among them
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_drain();
      case (phase)
        0:       cap = CAP_MAX;
        2:       cap = LBA_W'($urandom_range(256, 8192));
        3:       cap = '0;
        5:       cap = CAP_MAX;
        default: cap = LBA_W'($urandom);
      endcase
      write_capacity(cap);
      // phase 1 runs with no idling on either side
      in_idle_pct = (phase == 1) ? 0 : 28;
      out_idle_pct = (phase == 1) ? 0 : 28;
      phase_end = items_sent + PHASE_ITEMS;
      if (phase == 2) begin
        // receiver stalls for a long time while the sender keeps pushing
        in_idle_pct = 0;
        hold_output = 1;
        repeat (12) random_group();
        in_idle_pct = 28;
      end
      while (items_sent < phase_end) begin
        random_group();
        if (phase == 3 && items_sent >= phase_end - PHASE_ITEMS / 2 && board.pending() != 0)
          wait_for_drain();
      end
    end

    wait_for_drain();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
